### rtl/sfc_pkg.sv
// Shared constants and types of the sphere frustum cull core.
// No dependencies; imported by every module of the block.
package sfc_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int COEF_WIDTH_DEF  = 16;

	localparam int NUM_PLANES   = 4;
	localparam int NUM_AXES     = 3;
	localparam int PLANE_REG_W  = 48;
	localparam int COEF_FIELD_W = 16;
	localparam int WORD_W       = 32;
	localparam int HINT_W       = 2;

	localparam int FRAC_BITS  = 12;
	localparam int ROUND_BIAS = 'h800;
	localparam logic [WORD_W-1:0] DEPTH_CULLED = 32'h7FFF_FFFF;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = PLANE_REG_W;
	localparam logic [CFG_INDEX_W-1:0] REG_PLANE_0   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PLANE_1   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PLANE_2   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_PLANE_3   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_DEPTH = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_DEPTH = 3'd5;

	localparam int IN_DATA_W  = 4 * WORD_W;
	localparam int IN_USER_W  = 1 + HINT_W;
	localparam int OUT_DATA_W = 40;
	localparam int OUT_USER_W = 2;
	localparam int OUT_PAD_W  = OUT_DATA_W - WORD_W - HINT_W;

	typedef struct packed {
		logic                     depth_ok;
		logic [WORD_W-1:0]        neg_z;
		logic signed [WORD_W-1:0] radius;
		logic                     use_hint;
		logic [HINT_W-1:0]        hint;
	} ctrl_t;

endpackage

### rtl/sfc_front.sv
// First stage: twelve coordinate by coefficient products and the depth window test.
// Depends on sfc_pkg.
module sfc_front import sfc_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int COEF_WIDTH  = COEF_WIDTH_DEF
) (
	input  logic                                     clk,
	input  logic                                     en,
	input  logic [WORD_W-1:0]                        point_x,
	input  logic [WORD_W-1:0]                        point_y,
	input  logic [WORD_W-1:0]                        point_z,
	input  logic [WORD_W-1:0]                        radius,
	input  logic                                     use_hint,
	input  logic [HINT_W-1:0]                        hint_in,
	input  logic [NUM_PLANES-1:0][PLANE_REG_W-1:0]   planes,
	input  logic [WORD_W-1:0]                        min_depth,
	input  logic [WORD_W-1:0]                        max_depth,
	output logic signed [COORD_WIDTH+COEF_WIDTH-1:0] prod_s1 [NUM_PLANES][NUM_AXES],
	output ctrl_t                                    ctrl_s1
);

	localparam int PW = COORD_WIDTH + COEF_WIDTH;

	logic signed [COORD_WIDTH-1:0] pt [NUM_AXES];
	logic signed [WORD_W-1:0]      z_ext;
	logic [WORD_W-1:0]             neg_z;
	logic signed [WORD_W-1:0]      lo_lim;
	logic signed [WORD_W-1:0]      hi_lim;
	logic                          depth_ok;

	always_comb begin
		pt[0]    = point_x[COORD_WIDTH-1:0];
		pt[1]    = point_y[COORD_WIDTH-1:0];
		pt[2]    = point_z[COORD_WIDTH-1:0];
		z_ext    = WORD_W'(pt[2]);
		neg_z    = WORD_W'(0) - z_ext;
		lo_lim   = min_depth - radius;
		hi_lim   = max_depth + radius;
		depth_ok = ($signed(neg_z) >= lo_lim) && ($signed(neg_z) <= hi_lim);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int p = 0; p < NUM_PLANES; p++) begin
				for (int a = 0; a < NUM_AXES; a++) begin
					prod_s1[p][a] <= PW'(pt[a])
						* PW'($signed(planes[p][COEF_FIELD_W*a +: COEF_WIDTH]));
				end
			end
			ctrl_s1.depth_ok <= depth_ok;
			ctrl_s1.neg_z    <= neg_z;
			ctrl_s1.radius   <= radius;
			ctrl_s1.use_hint <= use_hint;
			ctrl_s1.hint     <= hint_in;
		end
	end

endmodule

### rtl/sfc_plane.sv
// Second and third stages for one plane: rounded sums, then the joint and split tests.
// Depends on sfc_pkg.
module sfc_plane import sfc_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int COEF_WIDTH  = COEF_WIDTH_DEF
) (
	input  logic                                     clk,
	input  logic                                     en_s2,
	input  logic                                     en_s3,
	input  logic signed [COORD_WIDTH+COEF_WIDTH-1:0] prod_x,
	input  logic signed [COORD_WIDTH+COEF_WIDTH-1:0] prod_y,
	input  logic signed [COORD_WIDTH+COEF_WIDTH-1:0] prod_z,
	input  logic signed [WORD_W-1:0]                 radius_s2,
	output logic                                     fail_joint_s3,
	output logic                                     fail_split_s3
);

	localparam int PW   = COORD_WIDTH + COEF_WIDTH;
	localparam int TW   = PW + 1;
	localparam int SW   = PW + 2;
	localparam int CMPW = (SW > WORD_W) ? SW : WORD_W;
	localparam logic signed [TW-1:0] BIAS_T = TW'(ROUND_BIAS);
	localparam logic signed [SW-1:0] BIAS_J = SW'(ROUND_BIAS);

	logic signed [TW-1:0]     rnd [NUM_AXES];
	logic signed [WORD_W-1:0] term_s2 [NUM_AXES];
	logic signed [SW-1:0]     jsum_s2;
	logic signed [SW-1:0]     jsh;
	logic signed [WORD_W-1:0] ssum;

	always_comb begin
		rnd[0] = (TW'(prod_x) + BIAS_T) >>> FRAC_BITS;
		rnd[1] = (TW'(prod_y) + BIAS_T) >>> FRAC_BITS;
		rnd[2] = (TW'(prod_z) + BIAS_T) >>> FRAC_BITS;
		jsh    = jsum_s2 >>> FRAC_BITS;
		ssum   = term_s2[0] + term_s2[1] + term_s2[2];
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			jsum_s2 <= SW'(prod_x) + SW'(prod_y) + SW'(prod_z) + BIAS_J;
			for (int a = 0; a < NUM_AXES; a++) begin
				term_s2[a] <= WORD_W'(rnd[a]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			fail_joint_s3 <= CMPW'(jsh) > CMPW'(radius_s2);
			fail_split_s3 <= ssum > radius_s2;
		end
	end

endmodule

### rtl/sfc_resolve.sv
// Fourth stage: plane walk from the hint, verdict, depth and new hint.
// Depends on sfc_pkg.
module sfc_resolve import sfc_pkg::*; (
	input  logic                  clk,
	input  logic                  en,
	input  logic [NUM_PLANES-1:0] fail_joint,
	input  logic [NUM_PLANES-1:0] fail_split,
	input  ctrl_t                 ctrl_s3,
	output logic                  visible_s4,
	output logic [WORD_W-1:0]     depth_s4,
	output logic [HINT_W-1:0]     hint_out_s4,
	output logic                  hint_written_s4
);

	logic              vis;
	logic              found;
	logic [HINT_W-1:0] idx;
	logic [HINT_W-1:0] hout;

	always_comb begin
		vis   = 1'b0;
		found = 1'b0;
		idx   = '0;
		hout  = '0;
		if (ctrl_s3.depth_ok) begin
			if (ctrl_s3.use_hint) begin
				if (!fail_joint[ctrl_s3.hint]) begin
					for (int k = 1; k < NUM_PLANES; k++) begin
						idx = ctrl_s3.hint + HINT_W'(k);
						if (!found && fail_joint[idx]) begin
							found = 1'b1;
							hout  = idx;
						end
					end
					vis = !found;
				end
			end else begin
				vis = ~|fail_split;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			visible_s4      <= vis;
			depth_s4        <= vis ? ctrl_s3.neg_z : DEPTH_CULLED;
			hint_out_s4     <= hout;
			hint_written_s4 <= found;
		end
	end

endmodule

### rtl/sphere_frustum_cull_core.sv
// Sphere frustum cull core: depth window and four-plane test of one point per item.
// Throughput: one item per cycle while m_tready does not stall the output.
// Stages: products and depth test, rounded sums, plane tests, plane walk and verdict.
// A stall at the output holds each full stage whose successor is full; empty stages still fill.
// Reset (arst_n low) empties the pipeline and clears all configuration registers to 0.
// Depends on sfc_pkg, sfc_front, sfc_plane and sfc_resolve.
module sphere_frustum_cull_core import sfc_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int COEF_WIDTH  = COEF_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_DATA_W-1:0]   s_tdata,   // point_x, point_y, point_z, radius
	input  logic [IN_USER_W-1:0]   s_tuser,   // use_hint, hint_in
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_DATA_W-1:0]  m_tdata,   // depth, hint_out, zero pad
	output logic [OUT_USER_W-1:0]  m_tuser,   // visible, hint_written
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int PW = COORD_WIDTH + COEF_WIDTH;

	logic [NUM_PLANES-1:0][PLANE_REG_W-1:0] plane_q;
	logic [WORD_W-1:0]                      min_depth_q;
	logic [WORD_W-1:0]                      max_depth_q;

	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	logic signed [PW-1:0] prod_s1 [NUM_PLANES][NUM_AXES];
	ctrl_t                ctrl_s1, ctrl_s2, ctrl_s3;
	logic [NUM_PLANES-1:0] fail_joint_s3, fail_split_s3;

	logic              visible_s4, hint_written_s4;
	logic [WORD_W-1:0] depth_s4;
	logic [HINT_W-1:0] hint_out_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q     <= '0;
			min_depth_q <= '0;
			max_depth_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PLANE_0:   plane_q[0]  <= cfg_data;
				REG_PLANE_1:   plane_q[1]  <= cfg_data;
				REG_PLANE_2:   plane_q[2]  <= cfg_data;
				REG_PLANE_3:   plane_q[3]  <= cfg_data;
				REG_MIN_DEPTH: min_depth_q <= cfg_data[WORD_W-1:0];
				REG_MAX_DEPTH: max_depth_q <= cfg_data[WORD_W-1:0];
				default: ;
			endcase
		end
	end

	// advance a stage when it is empty or its successor advances
	assign en_s4    = !v_s4 || m_tready;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign s_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= s_tvalid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	sfc_front #(
		.COORD_WIDTH (COORD_WIDTH),
		.COEF_WIDTH  (COEF_WIDTH)
	) u_front (
		.clk       (clk),
		.en        (en_s1),
		.point_x   (s_tdata[WORD_W-1:0]),
		.point_y   (s_tdata[2*WORD_W-1:WORD_W]),
		.point_z   (s_tdata[3*WORD_W-1:2*WORD_W]),
		.radius    (s_tdata[4*WORD_W-1:3*WORD_W]),
		.use_hint  (s_tuser[0]),
		.hint_in   (s_tuser[HINT_W:1]),
		.planes    (plane_q),
		.min_depth (min_depth_q),
		.max_depth (max_depth_q),
		.prod_s1   (prod_s1),
		.ctrl_s1   (ctrl_s1)
	);

	always_ff @(posedge clk) begin
		if (en_s2) ctrl_s2 <= ctrl_s1;
		if (en_s3) ctrl_s3 <= ctrl_s2;
	end

	for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
		sfc_plane #(
			.COORD_WIDTH (COORD_WIDTH),
			.COEF_WIDTH  (COEF_WIDTH)
		) u_plane (
			.clk           (clk),
			.en_s2         (en_s2),
			.en_s3         (en_s3),
			.prod_x        (prod_s1[p][0]),
			.prod_y        (prod_s1[p][1]),
			.prod_z        (prod_s1[p][2]),
			.radius_s2     (ctrl_s2.radius),
			.fail_joint_s3 (fail_joint_s3[p]),
			.fail_split_s3 (fail_split_s3[p])
		);
	end

	sfc_resolve u_resolve (
		.clk             (clk),
		.en              (en_s4),
		.fail_joint      (fail_joint_s3),
		.fail_split      (fail_split_s3),
		.ctrl_s3         (ctrl_s3),
		.visible_s4      (visible_s4),
		.depth_s4        (depth_s4),
		.hint_out_s4     (hint_out_s4),
		.hint_written_s4 (hint_written_s4)
	);

	assign m_tvalid = v_s4;
	assign m_tdata  = {OUT_PAD_W'(0), hint_out_s4, depth_s4};
	assign m_tuser  = {hint_written_s4, visible_s4};

endmodule

### rtl/sfc_checker.sv
// Port-level checks on the result stream of the sphere frustum cull core.
// Depends on sfc_pkg; bound to sphere_frustum_cull_core.
module sfc_checker import sfc_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic [OUT_USER_W-1:0] m_tuser
);

	a_hint_means_culled: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> !m_tuser[0])
		else $error("new hint reported on a visible item");

	a_culled_depth: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[WORD_W-1:0] == DEPTH_CULLED)
		else $error("culled item without the far depth code");

	a_hint_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[1] |-> m_tdata[WORD_W+HINT_W-1:WORD_W] == '0)
		else $error("hint field set without a new hint");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result item changed while stalled");

endmodule

bind sphere_frustum_cull_core sfc_checker u_sfc_checker (.*);
